/* sv/slb_pkg.sv */
// Shared types and constants of the slice list buffer chunker.
// Used by slb_table_ram, slb_walker and slice_list_buffer_chunker.
`default_nettype none
package slb_pkg;

   localparam int MAX_SLICES  = 32;
   localparam int SLICE_IDX_W = $clog2(MAX_SLICES);
   localparam int SLICE_CNT_W = $clog2(MAX_SLICES + 1);
   localparam int POS_W       = 48;
   localparam int LEN_W       = 32;
   localparam int PIECE_LIMIT = 32;
   localparam int PIECE_CNT_W = $clog2(PIECE_LIMIT + 1);

   localparam logic [LEN_W-1:0] BUFFER_ELEMENTS_RESET = LEN_W'(1048576);

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_ELEMENTS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILE_EXTENT     = 1'd1;

   localparam logic [1:0] ACT_CLEAR   = 2'd0;
   localparam logic [1:0] ACT_APPEND  = 2'd1;
   localparam logic [1:0] ACT_REQUEST = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_END     = 2'd1,
      STATUS_INVALID = 2'd2,
      STATUS_FULL    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_LEFT,
      S_TAKE,
      S_FINISH
   } walk_state_type;

   typedef struct packed {
      logic [LEN_W-1:0] buffer_elements;
      logic [POS_W-1:0] file_extent;
   } cfg_type;

   typedef struct packed {
      logic [POS_W-1:0] start;
      logic [POS_W-1:0] count;
   } entry_type;

endpackage
`default_nettype wire

/* sv/slice_list_buffer_chunker.sv */
// Top level of the slice list buffer chunker: configuration registers and wiring.
// Depends on slb_pkg, slb_table_ram and slb_walker.
//
// Commands arrive on the req_ channel (valid/ready): clear the slice table, append a
// slice, or request the pieces of the next buffer. Results leave on the rsp_ channel
// (valid/ready); each command yields one or more result transfers and the final one
// carries rsp_last. The csr_ port writes buffer_elements (index 0) and file_extent
// (index 1); the user must write them only while the block is idle, which the block
// itself does not enforce. A clear, an append or an unused action code gives its
// single result through S_FINISH. A next-buffer request steps through S_READ
// (memory read), S_LEFT (remaining length) and S_TAKE (cut at the buffer size) for
// each slice it visits, since every slice is read from the table memory; the final
// piece leaves through S_FINISH. At most 32 pieces are produced per request. One
// command is in work at a time. A result register and a one-piece hold stage
// separate the walk from the receiver: while the receiver stalls, the walk stops
// only when both are occupied. Reset clears the table length, the cursor, the
// remaining count and the result register; buffer_elements returns to 1048576 and
// file_extent to zero. The table memory needs no clearing pass.
`default_nettype none
module slice_list_buffer_chunker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [1:0]                          req_action,
   input  wire logic [slb_pkg::POS_W-1:0]           req_slice_start,
   input  wire logic [slb_pkg::POS_W-1:0]           req_slice_count,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [1:0]                               rsp_status,
   output logic [slb_pkg::POS_W-1:0]                rsp_piece_start,
   output logic [slb_pkg::LEN_W-1:0]                rsp_piece_count,
   output logic [slb_pkg::LEN_W-1:0]                rsp_buffer_total,
   output logic                                     rsp_last,
   input  wire logic                                csr_write_en,
   input  wire logic [slb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [slb_pkg::POS_W-1:0]           csr_write_data
);

   slb_pkg::cfg_type   cfg_ff, cfg_in;
   logic                              ram_wr_en;
   logic [slb_pkg::SLICE_IDX_W-1:0]   ram_wr_addr;
   slb_pkg::entry_type                ram_wr_data;
   logic                              ram_rd_en;
   logic [slb_pkg::SLICE_IDX_W-1:0]   ram_rd_addr;
   slb_pkg::entry_type                ram_rd_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            slb_pkg::CSR_BUFFER_ELEMENTS: begin
               cfg_in.buffer_elements = csr_write_data[slb_pkg::LEN_W-1:0];
            end
            slb_pkg::CSR_FILE_EXTENT: begin
               cfg_in.file_extent = csr_write_data;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.buffer_elements <= slb_pkg::BUFFER_ELEMENTS_RESET;
         cfg_ff.file_extent     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   slb_table_ram u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   slb_walker u_walker (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_slice_start  (req_slice_start),
      .req_slice_count  (req_slice_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_piece_start  (rsp_piece_start),
      .rsp_piece_count  (rsp_piece_count),
      .rsp_buffer_total (rsp_buffer_total),
      .rsp_last         (rsp_last),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .ram_rd_en        (ram_rd_en),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data)
   );

endmodule
`default_nettype wire

/* sv/slb_table_ram.sv */
// Slice table memory: one write port and one read port with registered data.
// Depends on slb_pkg for depth and entry layout.
`default_nettype none
module slb_table_ram (
   input  wire logic                            clock,
   input  wire logic                            wr_en,
   input  wire logic [slb_pkg::SLICE_IDX_W-1:0] wr_addr,
   input  wire slb_pkg::entry_type              wr_data,
   input  wire logic                            rd_en,
   input  wire logic [slb_pkg::SLICE_IDX_W-1:0] rd_addr,
   output slb_pkg::entry_type                   rd_data
);

   slb_pkg::entry_type mem [slb_pkg::MAX_SLICES];
   slb_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* sv/slb_walker.sv */
// Command sequencer: table bookkeeping, buffer walk and the result register.
// Depends on slb_pkg; drives the slice table memory slb_table_ram.
`default_nettype none
module slb_walker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire slb_pkg::cfg_type                cfg,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [1:0]                      req_action,
   input  wire logic [slb_pkg::POS_W-1:0]       req_slice_start,
   input  wire logic [slb_pkg::POS_W-1:0]       req_slice_count,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [1:0]                           rsp_status,
   output logic [slb_pkg::POS_W-1:0]            rsp_piece_start,
   output logic [slb_pkg::LEN_W-1:0]            rsp_piece_count,
   output logic [slb_pkg::LEN_W-1:0]            rsp_buffer_total,
   output logic                                 rsp_last,
   output logic                                 ram_wr_en,
   output logic [slb_pkg::SLICE_IDX_W-1:0]      ram_wr_addr,
   output slb_pkg::entry_type                   ram_wr_data,
   output logic                                 ram_rd_en,
   output logic [slb_pkg::SLICE_IDX_W-1:0]      ram_rd_addr,
   input  wire slb_pkg::entry_type              ram_rd_data
);

   localparam int PW = slb_pkg::POS_W;
   localparam int LW = slb_pkg::LEN_W;
   localparam int CW = slb_pkg::SLICE_CNT_W;
   localparam int NW = slb_pkg::PIECE_CNT_W;

   slb_pkg::walk_state_type state_ff, state_in;
   logic [CW-1:0]  held_ff, held_in;
   logic [CW-1:0]  cursor_ff, cursor_in;
   logic [PW-1:0]  offset_ff, offset_in;
   logic [PW-1:0]  remaining_ff, remaining_in;
   logic [PW-1:0]  last_start_ff, last_start_in;
   logic [PW:0]    last_end_ff, last_end_in;
   logic [LW-1:0]  room_ff, room_in;
   logic [LW-1:0]  total_ff, total_in;
   logic [NW-1:0]  npieces_ff, npieces_in;
   logic [PW-1:0]  left_ff, left_in;
   logic [PW-1:0]  pstart_ff, pstart_in;
   logic           pend_valid_ff, pend_valid_in;
   slb_pkg::status_type pend_status_ff, pend_status_in;
   logic [PW-1:0]  pend_start_ff, pend_start_in;
   logic [LW-1:0]  pend_count_ff, pend_count_in;
   logic [LW-1:0]  pend_total_ff, pend_total_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic [PW-1:0]  rsp_start_ff, rsp_start_in;
   logic [LW-1:0]  rsp_count_ff, rsp_count_in;
   logic [LW-1:0]  rsp_total_ff, rsp_total_in;
   logic           rsp_last_ff, rsp_last_in;

   logic           out_free;
   logic           accept;
   logic [PW:0]    slice_end;
   logic [PW:0]    rem_sum;
   logic [LW-1:0]  buf_size;
   logic [PW-1:0]  room_ext;
   logic [PW-1:0]  take_wide;
   logic [LW-1:0]  take;
   logic           take_nz;
   logic           take_all;
   logic [LW-1:0]  room_after;
   logic [NW-1:0]  npieces_next;
   logic           stall;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == slb_pkg::S_IDLE);
   assign accept    = req_valid && req_ready;

   assign slice_end = {1'b0, req_slice_start} + {1'b0, req_slice_count};
   assign rem_sum   = {1'b0, remaining_ff} + {1'b0, req_slice_count};
   assign buf_size  = (cfg.buffer_elements == '0) ? LW'(1) : cfg.buffer_elements;

   assign room_ext     = {{(PW-LW){1'b0}}, room_ff};
   assign take_wide    = (left_ff < room_ext) ? left_ff : room_ext;
   assign take         = take_wide[LW-1:0];
   assign take_nz      = (take != '0);
   assign take_all     = (take_wide == left_ff);
   assign room_after   = room_ff - take;
   assign npieces_next = npieces_ff + NW'(take_nz);
   assign stall        = take_nz && pend_valid_ff && !out_free;

   assign ram_wr_addr = held_ff[slb_pkg::SLICE_IDX_W-1:0];
   assign ram_wr_data = '{start: req_slice_start, count: req_slice_count};
   assign ram_rd_addr = cursor_ff[slb_pkg::SLICE_IDX_W-1:0];

   always_comb begin
      state_in       = state_ff;
      held_in        = held_ff;
      cursor_in      = cursor_ff;
      offset_in      = offset_ff;
      remaining_in   = remaining_ff;
      last_start_in  = last_start_ff;
      last_end_in    = last_end_ff;
      room_in        = room_ff;
      total_in       = total_ff;
      npieces_in     = npieces_ff;
      left_in        = left_ff;
      pstart_in      = pstart_ff;
      pend_valid_in  = pend_valid_ff;
      pend_status_in = pend_status_ff;
      pend_start_in  = pend_start_ff;
      pend_count_in  = pend_count_ff;
      pend_total_in  = pend_total_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_start_in   = rsp_start_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_last_in    = rsp_last_ff;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;

      unique case (state_ff)
         slb_pkg::S_IDLE: begin
            if (accept) begin
               pend_start_in = '0;
               pend_count_in = '0;
               pend_total_in = '0;
               unique case (req_action)
                  slb_pkg::ACT_CLEAR: begin
                     held_in        = '0;
                     cursor_in      = '0;
                     offset_in      = '0;
                     remaining_in   = '0;
                     pend_valid_in  = 1'b1;
                     pend_status_in = slb_pkg::STATUS_OK;
                     state_in       = slb_pkg::S_FINISH;
                  end
                  slb_pkg::ACT_APPEND: begin
                     pend_valid_in = 1'b1;
                     state_in      = slb_pkg::S_FINISH;
                     if (held_ff >= CW'(slb_pkg::MAX_SLICES)) begin
                        pend_status_in = slb_pkg::STATUS_FULL;
                     end else if (slice_end > {1'b0, cfg.file_extent}) begin
                        pend_status_in = slb_pkg::STATUS_INVALID;
                     end else if (held_ff != '0 && (req_slice_start < last_start_ff ||
                                  last_end_ff > {1'b0, req_slice_start})) begin
                        pend_status_in = slb_pkg::STATUS_INVALID;
                     end else begin
                        pend_status_in = slb_pkg::STATUS_OK;
                        ram_wr_en      = 1'b1;
                        held_in        = held_ff + CW'(1);
                        last_start_in  = req_slice_start;
                        last_end_in    = slice_end;
                        remaining_in   = rem_sum[PW] ? '1 : rem_sum[PW-1:0];
                     end
                  end
                  slb_pkg::ACT_REQUEST: begin
                     pend_valid_in = 1'b0;
                     total_in      = '0;
                     npieces_in    = '0;
                     if (remaining_ff == '0) begin
                        state_in = slb_pkg::S_FINISH;
                     end else begin
                        room_in  = (remaining_ff < {{(PW-LW){1'b0}}, buf_size})
                                   ? remaining_ff[LW-1:0] : buf_size;
                        state_in = slb_pkg::S_READ;
                     end
                  end
                  default: begin
                     pend_valid_in  = 1'b1;
                     pend_status_in = slb_pkg::STATUS_OK;
                     state_in       = slb_pkg::S_FINISH;
                  end
               endcase
            end
         end
         slb_pkg::S_READ: begin
            if (cursor_ff >= held_ff) begin
               remaining_in = '0;
               state_in     = slb_pkg::S_FINISH;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = slb_pkg::S_LEFT;
            end
         end
         slb_pkg::S_LEFT: begin
            left_in   = (ram_rd_data.count > offset_ff) ? ram_rd_data.count - offset_ff : '0;
            pstart_in = ram_rd_data.start + offset_ff;
            state_in  = slb_pkg::S_TAKE;
         end
         slb_pkg::S_TAKE: begin
            if (!stall) begin
               if (take_nz) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = pend_status_ff;
                     rsp_start_in  = pend_start_ff;
                     rsp_count_in  = pend_count_ff;
                     rsp_total_in  = pend_total_ff;
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in  = 1'b1;
                  pend_status_in = slb_pkg::STATUS_OK;
                  pend_start_in  = pstart_ff;
                  pend_count_in  = take;
                  pend_total_in  = total_ff + take;
                  total_in       = total_ff + take;
               end
               if (take_all) begin
                  offset_in = '0;
                  cursor_in = cursor_ff + CW'(1);
               end else begin
                  offset_in = offset_ff + {{(PW-LW){1'b0}}, take};
               end
               room_in      = room_after;
               remaining_in = remaining_ff - {{(PW-LW){1'b0}}, take};
               npieces_in   = npieces_next;
               if (room_after == '0 || npieces_next == NW'(slb_pkg::PIECE_LIMIT)) begin
                  state_in = slb_pkg::S_FINISH;
               end else begin
                  state_in = slb_pkg::S_READ;
               end
            end
         end
         slb_pkg::S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               if (pend_valid_ff) begin
                  rsp_status_in = pend_status_ff;
                  rsp_start_in  = pend_start_ff;
                  rsp_count_in  = pend_count_ff;
                  rsp_total_in  = pend_total_ff;
               end else begin
                  rsp_status_in = slb_pkg::STATUS_END;
                  rsp_start_in  = '0;
                  rsp_count_in  = '0;
                  rsp_total_in  = '0;
               end
               pend_valid_in = 1'b0;
               state_in      = slb_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = slb_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= slb_pkg::S_IDLE;
         held_ff       <= '0;
         cursor_ff     <= '0;
         offset_ff     <= '0;
         remaining_ff  <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_ff       <= held_in;
         cursor_ff     <= cursor_in;
         offset_ff     <= offset_in;
         remaining_ff  <= remaining_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_start_ff  <= last_start_in;
      last_end_ff    <= last_end_in;
      room_ff        <= room_in;
      total_ff       <= total_in;
      npieces_ff     <= npieces_in;
      left_ff        <= left_in;
      pstart_ff      <= pstart_in;
      pend_status_ff <= pend_status_in;
      pend_start_ff  <= pend_start_in;
      pend_count_ff  <= pend_count_in;
      pend_total_ff  <= pend_total_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_start_ff   <= rsp_start_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_piece_start  = rsp_start_ff;
   assign rsp_piece_count  = rsp_count_ff;
   assign rsp_buffer_total = rsp_total_ff;
   assign rsp_last         = rsp_last_ff;

endmodule
`default_nettype wire
